FILE: rtl/bhpq_pkg.sv
// Package for the binary heap priority queue.
// Holds sizes, command, status and state codes, and the word types of the ports.
// Used by every module in rtl/; depends on nothing.
package bhpq_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_PEEK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHK,
        S_DN_RDR,
        S_DN_PICK,
        S_DN_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cmd                           command;
        logic signed [VALUE_WIDTH-1:0]  data_value;
    } t_in_word;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0]  top_value;
        logic [CNT_W-1:0]               entry_count;
        logic                           is_empty;
        t_status                        status;
    } t_out_word;

    typedef struct packed {
        logic                           we;
        logic [ADDR_W-1:0]              addr;
        logic signed [VALUE_WIDTH-1:0]  data;
    } t_ram_wr;

endpackage

FILE: rtl/bhpq_ram.sv
// Heap storage: one write port and one read port with registered read data.
// Depends on bhpq_pkg for sizes and the write port struct.
module bhpq_ram (
    input  logic                                    i_clk,
    input  bhpq_pkg::t_ram_wr                       i_wr,
    input  logic [bhpq_pkg::ADDR_W-1:0]             i_raddr,
    output logic signed [bhpq_pkg::VALUE_WIDTH-1:0] o_rdata
);

    logic signed [bhpq_pkg::VALUE_WIDTH-1:0] r_mem [bhpq_pkg::DEPTH];
    logic signed [bhpq_pkg::VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/bhpq_cmp.sv
// Shared ordering compare: tells whether value a must sit above value b.
// Depends on bhpq_pkg for the value width.
module bhpq_cmp (
    input  logic signed [bhpq_pkg::VALUE_WIDTH-1:0] i_a,
    input  logic signed [bhpq_pkg::VALUE_WIDTH-1:0] i_b,
    input  logic                                    i_max_mode,
    output logic                                    o_above
);

    // Equal values never rank above each other, so no swap happens on ties.
    assign o_above = i_max_mode ? (i_a > i_b) : (i_a < i_b);

endmodule

FILE: rtl/binary_heap_priority_queue.sv
// Top level of the binary heap priority queue: command sequencer and result register.
// Depends on bhpq_pkg, bhpq_ram (heap storage) and bhpq_cmp (shared compare).
//
// The queue holds up to DEPTH signed values in a single-port-write memory in heap
// order (children of entry i at 2i+1 and 2i+2). Each accepted input word carries a
// command: insert, pop, clear or peek; each produces exactly one result word with the
// top value (zero when empty), the entry count, an empty flag and a status (insert
// into a full heap and pop from an empty heap leave the heap untouched and are
// flagged). The order_mode register, written through i_cfg_we/i_cfg_wdata, picks a
// min-heap (0) or max-heap (1); it affects later compares only. The user must write
// it only while the queue is idle; the block itself does not enforce this. Work goes
// through one compare unit and one memory read port under a sequencer, so the queue
// takes one word at a time and holds o_in_stall high until it is done. Clear and
// peek go straight to the result, as do flagged commands and a pop that empties the
// heap. An insert walks toward the root, each level a parent read, then compare and
// move; it climbs at most log2(DEPTH) = 6 levels. A pop reads the last entry and
// walks down, each level a left read, a right read, a child pick, then compare and
// move (no pick on a level with no right child). A pop leaves at most DEPTH - 1
// entries, so it descends at most 5 levels. The result register lets the next word
// be taken while a finished result still waits for the output side.
module binary_heap_priority_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bhpq_pkg::t_in_word    i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bhpq_pkg::t_out_word   o_out_word
);

    localparam int VW = bhpq_pkg::VALUE_WIDTH;
    localparam int AW = bhpq_pkg::ADDR_W;
    localparam int CW = bhpq_pkg::CNT_W;

    // Control state.
    bhpq_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_order_mode;
    logic              r_out_valid, n_out_valid;

    // Datapath state. r_val is the value being sifted, r_best the better child
    // seen so far, and r_top a copy of the root entry kept up to date on writes.
    logic [AW-1:0]          r_pos, n_pos;
    logic signed [VW-1:0]   r_val, n_val;
    logic signed [VW-1:0]   r_best, n_best;
    logic [AW-1:0]          r_best_idx, n_best_idx;
    logic signed [VW-1:0]   r_top;
    bhpq_pkg::t_status      r_status, n_status;
    bhpq_pkg::t_out_word    r_out_word, n_out_word;

    // Memory and compare unit hookup.
    bhpq_pkg::t_ram_wr      w_wr;
    logic [AW-1:0]          w_raddr;
    logic signed [VW-1:0]   w_rdata;
    logic signed [VW-1:0]   w_cmp_a, w_cmp_b;
    logic                   w_above;

    logic                   w_accept;
    logic                   w_out_load;
    logic [CW-1:0]          w_left;     // left child index of r_pos
    logic [CW:0]            w_right;    // right child index, one bit wider
    logic                   w_left_in;
    logic                   w_right_in;
    logic [AW-1:0]          w_parent;

    bhpq_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bhpq_cmp u_cmp (
        .i_a        (w_cmp_a),
        .i_b        (w_cmp_b),
        .i_max_mode (r_order_mode),
        .o_above    (w_above)
    );

    assign w_accept   = i_in_valid && (r_state == bhpq_pkg::S_IDLE);
    assign w_out_load = (r_state == bhpq_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign w_left     = {r_pos, 1'b1};
    assign w_right    = {1'b0, w_left} + (CW + 1)'(1);
    assign w_left_in  = w_left < r_count;
    assign w_right_in = w_right < {1'b0, r_count};
    assign w_parent   = (r_pos - AW'(1)) >> 1;

    // Next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_pos      = r_pos;
        n_val      = r_val;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_status   = r_status;
        case (r_state)
            bhpq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_status = bhpq_pkg::STAT_OK;
                    n_state  = bhpq_pkg::S_DONE;
                    case (i_in_word.command)
                        bhpq_pkg::CMD_INSERT: begin
                            if (r_count == CW'(bhpq_pkg::DEPTH)) begin
                                n_status = bhpq_pkg::STAT_FULL;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_pos   = r_count[AW-1:0];
                                n_val   = i_in_word.data_value;
                                n_state = bhpq_pkg::S_UP_CHK;
                            end
                        end
                        bhpq_pkg::CMD_POP: begin
                            if (r_count == '0) begin
                                n_status = bhpq_pkg::STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                                // The last entry is read this cycle unless the heap empties.
                                if (r_count != CW'(1)) begin
                                    n_state = bhpq_pkg::S_DN_LOAD;
                                end
                            end
                        end
                        bhpq_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            bhpq_pkg::S_UP_CHK: begin
                if (r_pos == '0) begin
                    n_state = bhpq_pkg::S_DONE;
                end else begin
                    n_state = bhpq_pkg::S_UP_CMP;
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                if (w_above) begin
                    n_pos   = w_parent;
                    n_state = bhpq_pkg::S_UP_CHK;
                end else begin
                    n_state = bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DN_LOAD: begin
                n_val   = w_rdata;
                n_pos   = '0;
                n_state = bhpq_pkg::S_DN_CHK;
            end
            bhpq_pkg::S_DN_CHK: begin
                if (w_left_in) begin
                    n_state = bhpq_pkg::S_DN_RDR;
                end else begin
                    n_state = bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DN_RDR: begin
                n_best     = w_rdata;
                n_best_idx = w_left[AW-1:0];
                if (w_right_in) begin
                    n_state = bhpq_pkg::S_DN_PICK;
                end else begin
                    n_state = bhpq_pkg::S_DN_CMP;
                end
            end
            bhpq_pkg::S_DN_PICK: begin
                if (w_above) begin
                    n_best     = w_rdata;
                    n_best_idx = w_right[AW-1:0];
                end
                n_state = bhpq_pkg::S_DN_CMP;
            end
            bhpq_pkg::S_DN_CMP: begin
                if (w_above) begin
                    n_pos   = r_best_idx;
                    n_state = bhpq_pkg::S_DN_CHK;
                end else begin
                    n_state = bhpq_pkg::S_DONE;
                end
            end
            bhpq_pkg::S_DONE: begin
                if (w_out_load) begin
                    n_state = bhpq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bhpq_pkg::S_IDLE;
            end
        endcase
    end

    // Memory port, compare operands and handshake outputs.
    always_comb begin
        w_wr      = '0;
        w_raddr   = r_pos;
        w_cmp_a   = r_val;
        w_cmp_b   = w_rdata;
        case (r_state)
            bhpq_pkg::S_IDLE: begin
                // Address of the last entry, used by a pop.
                w_raddr = AW'(r_count - CW'(1));
            end
            bhpq_pkg::S_UP_CHK: begin
                w_raddr = w_parent;
                if (r_pos == '0) begin
                    w_wr = '{we: 1'b1, addr: r_pos, data: r_val};
                end
            end
            bhpq_pkg::S_UP_CMP: begin
                // The parent moves down into the hole, or the value settles here.
                w_wr = '{we: 1'b1, addr: r_pos, data: (w_above ? w_rdata : r_val)};
            end
            bhpq_pkg::S_DN_CHK: begin
                w_raddr = w_left[AW-1:0];
                if (!w_left_in) begin
                    w_wr = '{we: 1'b1, addr: r_pos, data: r_val};
                end
            end
            bhpq_pkg::S_DN_RDR: begin
                w_raddr = w_right[AW-1:0];
            end
            bhpq_pkg::S_DN_PICK: begin
                w_cmp_a = w_rdata;
                w_cmp_b = r_best;
            end
            bhpq_pkg::S_DN_CMP: begin
                w_cmp_a = r_best;
                w_cmp_b = r_val;
                w_wr    = '{we: 1'b1, addr: r_pos, data: (w_above ? r_best : r_val)};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_out_word.top_value   = (r_count == '0) ? '0 : r_top;
        n_out_word.entry_count = r_count;
        n_out_word.is_empty    = (r_count == '0);
        n_out_word.status      = r_status;
        n_out_valid            = w_out_load || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bhpq_pkg::S_IDLE;
            r_count      <= '0;
            r_order_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_order_mode <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_status   <= n_status;
        if (w_wr.we && (w_wr.addr == '0)) begin
            r_top <= w_wr.data;
        end
        if (w_out_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_in_stall  = (r_state != bhpq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The entry count never passes the capacity.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(bhpq_pkg::DEPTH))
        else $error("entry count above capacity");

    // An insert into a heap with room grows the count by one.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.command == bhpq_pkg::CMD_INSERT)
            && (r_count != CW'(bhpq_pkg::DEPTH)))
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow the count");

    // A pop from a nonempty heap shrinks the count by one.
    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.command == bhpq_pkg::CMD_POP) && (r_count != '0))
        |=> (r_count == $past(r_count) - CW'(1)))
        else $error("pop did not shrink the count");

    // A full-drop result always reports a full heap.
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.status == bhpq_pkg::STAT_FULL))
        |-> (o_out_word.entry_count == CW'(bhpq_pkg::DEPTH)))
        else $error("full status with room left");

endmodule
